// ===== design/tdpt_pkg.sv =====
// ============================================================================
// tdpt_pkg: shared types and constants for the trial division prime test
// Command and status bundles between controller and datapath.
// ============================================================================
package tdpt_pkg;

    // default operand width, two's complement
    localparam int VALUE_WIDTH_DEF = 32;

    // first trial divisor and its square
    localparam int FIRST_DIVISOR = 2;
    localparam int FIRST_SQUARE  = FIRST_DIVISOR * FIRST_DIVISOR;

    typedef struct packed {
        logic load;      // capture operand, reset divisor to 2
        logic div_init;  // start remainder for current divisor
        logic div_step;  // one restoring remainder step
        logic next_div;  // advance divisor and its square
    } tdpt_cmd_t;

    typedef struct packed {
        logic too_low;   // operand negative or below 2
        logic bound_ok;  // divisor squared <= operand
        logic div_last;  // current step is the last remainder step
        logic rem_zero;  // remainder of last division is zero
    } tdpt_sts_t;

endpackage

// ===== design/tdpt_datapath.sv =====
// ============================================================================
// tdpt_datapath: operand, divisor, square and radix-2 remainder unit
// One remainder bit per cycle; divisor square kept by running sum.
// ============================================================================
module tdpt_datapath
    import tdpt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [VALUE_WIDTH-1:0] number,
    input  tdpt_cmd_t              cmd,
    output tdpt_sts_t              sts
);

    localparam int MAG_WIDTH = VALUE_WIDTH - 1;
    localparam int CNT_WIDTH = $clog2(MAG_WIDTH);
    localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(MAG_WIDTH - 1);

    logic                   neg_reg;
    logic [MAG_WIDTH-1:0]   val_reg;
    logic [VALUE_WIDTH-1:0] div_reg;
    logic [VALUE_WIDTH-1:0] sq_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [MAG_WIDTH-1:0]   dvd_reg;
    logic [CNT_WIDTH-1:0]   cnt_reg;

    logic [VALUE_WIDTH-1:0] trial;
    logic [VALUE_WIDTH-1:0] rem_next;
    logic [VALUE_WIDTH-1:0] sq_next;

    // shift in next dividend bit, subtract divisor if it fits
    always_comb
    begin
        trial = {rem_reg[VALUE_WIDTH-2:0], dvd_reg[MAG_WIDTH-1]};
        if (trial >= div_reg)
        begin
            rem_next = trial - div_reg;
        end
        else
        begin
            rem_next = trial;
        end
        // (d+1)^2 = d^2 + 2d + 1
        sq_next = sq_reg + {div_reg[VALUE_WIDTH-2:0], 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg <= number[VALUE_WIDTH-1];
            val_reg <= number[MAG_WIDTH-1:0];
            div_reg <= VALUE_WIDTH'(FIRST_DIVISOR);
            sq_reg  <= VALUE_WIDTH'(FIRST_SQUARE);
        end
        else if (cmd.next_div)
        begin
            div_reg <= div_reg + 1'b1;
            sq_reg  <= sq_next;
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            dvd_reg <= val_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[MAG_WIDTH-2:0], 1'b0};
        end
    end

    assign sts.too_low  = neg_reg || (val_reg < MAG_WIDTH'(FIRST_DIVISOR));
    assign sts.bound_ok = sq_reg <= {1'b0, val_reg};
    assign sts.div_last = cnt_reg == LAST_STEP;
    assign sts.rem_zero = rem_reg == '0;

endmodule

// ===== design/tdpt_ctrl.sv =====
// ============================================================================
// tdpt_ctrl: sequencer for the trial division loop
// Drives the datapath, issues busy and the one-cycle result strobe.
// ============================================================================
module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  tdpt_sts_t sts,
    output tdpt_cmd_t cmd,
    output logic      busy,
    output logic      done,
    output logic      prime
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TEST = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EVAL = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       done_reg, done_next;
    logic       prime_reg, prime_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        prime_next = prime_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (sts.too_low)
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (!sts.bound_ok)
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (sts.rem_zero)
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.next_div = 1'b1;
                    state_next   = ST_TEST;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            prime_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            prime_reg <= prime_next;
        end
    end

    assign busy  = state_reg != ST_IDLE;
    assign done  = done_reg;
    assign prime = prime_reg;

endmodule

// ===== design/trial_division_prime_test_top.sv =====
// ============================================================================
// trial_division_prime_test_top: primality test by trial division
// Controller plus datapath with a bit-serial remainder unit.
// ============================================================================
// Usage:
//   Raise start with number valid while busy is low; the request is taken
//   at that edge and busy goes high the next cycle. number is two's
//   complement; negative values, 0 and 1 report not prime.
//   done is high for exactly one cycle with the answer on prime, which
//   keeps it; busy is low in that cycle, so a new request may go with it.
//   The receiver cannot stall: done is a strobe, not a handshake.
// Sequence:
//   Each divisor tried takes VALUE_WIDTH - 1 remainder steps, one bound
//   test and one check.
//   The remainder unit retires one dividend bit per cycle and sets the rate.
//   Divisors run upward from 2 while divisor squared <= number, so the worst
//   case at 32 bits (a prime near 2^31) tries 46339 divisors.
// Reset:
//   rst_n is asynchronous, active low; the block returns idle, no strobe.
//   No state but the last answer on prime carries over between requests.
// ============================================================================
module trial_division_prime_test_top
    import tdpt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] number,
    output logic                   busy,
    output logic                   done,
    output logic                   prime
);

    tdpt_cmd_t cmd;
    tdpt_sts_t sts;

    // sequencer: bound test, remainder loop, verdict
    tdpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .prime (prime)
    );

    // operand, divisor, running square and remainder unit
    tdpt_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number),
        .cmd    (cmd),
        .sts    (sts)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // a taken request always starts work
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // result strobe comes only as the block returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("done without completing a request");

    // one result per request: strobe lasts a single cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

endmodule
